// ----- sv/fdir_pkg.sv -----
`default_nettype none

package fdir_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int DIR_COUNT   = 8;
    localparam int SCALED_W    = HEIGHT_BITS + 8;

    localparam logic [7:0] CARD_WEIGHT = 8'd141;
    localparam logic [7:0] DIAG_WEIGHT = 8'd100;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;
    typedef logic [HEIGHT_BITS-1:0]        drop_t;
    typedef logic [SCALED_W-1:0]           scaled_t;
    typedef logic [DIR_COUNT-1:0]          dir_mask_t;

    localparam height_t NODATA_RESET = height_t'(-9999);

    // Neighbor order N,NE,E,SE,S,SW,W,NW; odd indexes are diagonals.
    // D8 code bit for neighbor d is (d + 6) mod 8.
    function automatic dir_mask_t dir_code(input int d);
        dir_mask_t code;
        code = '0;
        code[(d + 6) % DIR_COUNT] = 1'b1;
        return code;
    endfunction

    typedef struct packed {
        logic    lower;
        logic    higher;
        logic    eligible;
        scaled_t scaled;
    } nb_eval_t;

    typedef struct packed {
        dir_mask_t steepest_code;
        dir_mask_t downslope_mask;
        logic      is_sink;
        logic      is_flat;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/fdir_neighbor.sv -----
`default_nettype none

module fdir_neighbor (
    input  wire fdir_pkg::height_t  center,
    input  wire fdir_pkg::height_t  neighbor,
    input  wire fdir_pkg::height_t  nodata,
    input  wire logic               present,
    input  wire logic               diagonal,
    output fdir_pkg::nb_eval_t      eval
);
    import fdir_pkg::*;

    logic signed [HEIGHT_BITS:0] diff;
    drop_t                       drop;
    logic [7:0]                  weight;

    always_comb begin
        diff   = {center[HEIGHT_BITS-1], center} - {neighbor[HEIGHT_BITS-1], neighbor};
        drop   = diff[HEIGHT_BITS-1:0];
        weight = diagonal ? DIAG_WEIGHT : CARD_WEIGHT;

        eval.lower    = present && (center > neighbor);
        eval.higher   = present && (center < neighbor);
        eval.eligible = eval.lower && (neighbor != nodata);
        eval.scaled   = scaled_t'(drop) * scaled_t'(weight);
    end

endmodule

`default_nettype wire

// ----- sv/fdir_select.sv -----
`default_nettype none

module fdir_select (
    input  wire fdir_pkg::height_t     center,
    input  wire fdir_pkg::height_t     nb_height [fdir_pkg::DIR_COUNT],
    input  wire fdir_pkg::dir_mask_t   present,
    input  wire fdir_pkg::height_t     nodata,
    output fdir_pkg::result_t          result
);
    import fdir_pkg::*;

    nb_eval_t  eval [DIR_COUNT];
    scaled_t   l1_val  [4];
    dir_mask_t l1_code [4];
    scaled_t   l2_val  [2];
    dir_mask_t l2_code [2];
    dir_mask_t lower_mask;
    dir_mask_t higher_mask;
    dir_mask_t down_mask;
    scaled_t   cand_val  [DIR_COUNT];
    dir_mask_t cand_code [DIR_COUNT];
    logic      center_ok;
    logic      sink;
    logic      flat;
    dir_mask_t steep;

    for (genvar d = 0; d < DIR_COUNT; d++) begin : g_nb
        fdir_neighbor u_nb (
            .center   (center),
            .neighbor (nb_height[d]),
            .nodata   (nodata),
            .present  (present[d]),
            .diagonal (1'(d % 2)),
            .eval     (eval[d])
        );
    end

    always_comb begin
        down_mask = '0;
        for (int d = 0; d < DIR_COUNT; d++) begin
            lower_mask[d]  = eval[d].lower;
            higher_mask[d] = eval[d].higher;
            cand_val[d]    = eval[d].eligible ? eval[d].scaled : '0;
            cand_code[d]   = eval[d].eligible ? dir_code(d) : '0;
            if (eval[d].lower) begin
                down_mask = down_mask | dir_code(d);
            end
        end

        // max tree; the right side wins only when strictly greater
        for (int i = 0; i < 4; i++) begin
            if (cand_val[2*i+1] > cand_val[2*i]) begin
                l1_val[i]  = cand_val[2*i+1];
                l1_code[i] = cand_code[2*i+1];
            end else begin
                l1_val[i]  = cand_val[2*i];
                l1_code[i] = cand_code[2*i];
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (l1_val[2*i+1] > l1_val[2*i]) begin
                l2_val[i]  = l1_val[2*i+1];
                l2_code[i] = l1_code[2*i+1];
            end else begin
                l2_val[i]  = l1_val[2*i];
                l2_code[i] = l1_code[2*i];
            end
        end
        steep = (l2_val[1] > l2_val[0]) ? l2_code[1] : l2_code[0];

        center_ok = (center > height_t'(0));
        sink      = &higher_mask;
        flat      = (&present) && !(|lower_mask) && !sink;

        result.steepest_code  = center_ok ? steep : '0;
        result.downslope_mask = center_ok ? down_mask : '0;
        result.is_sink        = center_ok && sink;
        result.is_flat        = center_ok && flat;
    end

endmodule

`default_nettype wire

// ----- sv/d8_mfd_flow_direction.sv -----
`default_nettype none

// Channel  Direction  Ports
// cfg      in         cfg_valid / cfg_ready, cfg_nodata_height
// s        in         s_valid / s_ready, center + eight neighbor heights, presence
// m        out        m_valid / m_ready, steepest code, downslope mask, sink, flat
//
// Registered path: input word register, then result register.
// One word per cycle sustained while m is ready; the neighbor compares and max tree sit between the two.
// aresetn (sync, active low) clears valids and sets nodata_height to -9999.
// A stall on m holds the result register and backs up through the input register.

module d8_mfd_flow_direction (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire fdir_pkg::height_t   cfg_nodata_height,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fdir_pkg::height_t   s_center_height,
    input  wire fdir_pkg::height_t   s_north_height,
    input  wire fdir_pkg::height_t   s_northeast_height,
    input  wire fdir_pkg::height_t   s_east_height,
    input  wire fdir_pkg::height_t   s_southeast_height,
    input  wire fdir_pkg::height_t   s_south_height,
    input  wire fdir_pkg::height_t   s_southwest_height,
    input  wire fdir_pkg::height_t   s_west_height,
    input  wire fdir_pkg::height_t   s_northwest_height,
    input  wire fdir_pkg::dir_mask_t s_neighbour_present,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output fdir_pkg::dir_mask_t      m_steepest_code,
    output fdir_pkg::dir_mask_t      m_downslope_mask,
    output logic                     m_is_sink,
    output logic                     m_is_flat
);
    import fdir_pkg::*;

    height_t   nodata_reg;
    logic      in_valid_reg;
    height_t   center_reg;
    height_t   nb_reg [DIR_COUNT];
    dir_mask_t present_reg;
    logic      out_valid_reg;
    result_t   result_reg;
    result_t   result_next;
    logic      out_take;
    logic      in_take;

    assign cfg_ready = 1'b1;

    assign out_take = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_take;
    assign in_take  = s_valid && s_ready;

    fdir_select u_select (
        .center    (center_reg),
        .nb_height (nb_reg),
        .present   (present_reg),
        .nodata    (nodata_reg),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodata_reg    <= NODATA_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                nodata_reg <= cfg_nodata_height;
            end
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (out_take) begin
                in_valid_reg <= 1'b0;
            end
            if (out_take) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            center_reg  <= s_center_height;
            nb_reg[0]   <= s_north_height;
            nb_reg[1]   <= s_northeast_height;
            nb_reg[2]   <= s_east_height;
            nb_reg[3]   <= s_southeast_height;
            nb_reg[4]   <= s_south_height;
            nb_reg[5]   <= s_southwest_height;
            nb_reg[6]   <= s_west_height;
            nb_reg[7]   <= s_northwest_height;
            present_reg <= s_neighbour_present;
        end
        if (out_take && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_steepest_code  = result_reg.steepest_code;
    assign m_downslope_mask = result_reg.downslope_mask;
    assign m_is_sink        = result_reg.is_sink;
    assign m_is_flat        = result_reg.is_flat;

endmodule

`default_nettype wire
